/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pedal timed switch controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, skipped while reset is applied.
`define PTSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define PTSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/ptsc_pkg.sv */
// ----------------------------------------------------------------------------
// Pedal timed switch controller package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package ptsc_pkg;

  // Field and register widths.
  localparam int unsigned DebW     = 8;
  localparam int unsigned WinW     = 16;
  localparam int unsigned BlinkW   = 16;
  localparam int unsigned GainW    = 8;
  localparam int unsigned BaseW    = 16;
  localparam int unsigned SampleW  = 10;
  localparam int unsigned ScaledW  = GainW + SampleW;
  localparam int unsigned OntimeW  = 19;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;
  localparam int unsigned RegIdxW  = 3;

  // Register reset values.
  localparam logic [DebW-1:0]   DebounceReset = 8'd25;
  localparam logic [WinW-1:0]   DoubleReset   = 16'd400;
  localparam logic [BlinkW-1:0] BlinkReset    = 16'd100;
  localparam logic [GainW-1:0]  GainReset     = 8'd90;
  localparam logic [BaseW-1:0]  BaseReset     = 16'd12000;

  // Register indexes (byte address divided by four).
  typedef enum logic [RegIdxW-1:0] {
    RegDebounce = 3'd0,
    RegDouble   = 3'd1,
    RegBlink    = 3'd2,
    RegGain     = 3'd3,
    RegBase     = 3'd4
  } reg_idx_e;

  // Controller mode.
  typedef enum logic [2:0] {
    ModeOff   = 3'b001,
    ModeTimed = 3'b010,
    ModeOn    = 3'b100
  } mode_e;

  // Configuration set handed from the register file to the core.
  typedef struct packed {
    logic [DebW-1:0]   debounce_ticks;
    logic [WinW-1:0]   double_press_ticks;
    logic [BlinkW-1:0] blink_ticks;
    logic [GainW-1:0]  ontime_gain;
    logic [BaseW-1:0]  ontime_base;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic switch_on;
    logic led_on;
  } result_t;

endpackage

/* src/ptsc_in_if.sv */
// ----------------------------------------------------------------------------
// Tick request channel
// Valid/ready channel carrying the pedal level, absence sense and pot sample.
// ----------------------------------------------------------------------------
interface ptsc_in_if import ptsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               pedal_level;
  logic               pedal_absent;
  logic [SampleW-1:0] pot_sample;

  modport source (output valid, output pedal_level, output pedal_absent,
                  output pot_sample, input ready);
  modport sink   (input valid, input pedal_level, input pedal_absent,
                  input pot_sample, output ready);
endinterface

/* src/ptsc_out_if.sv */
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel carrying the switch and LED drive levels.
// ----------------------------------------------------------------------------
interface ptsc_out_if import ptsc_pkg::*; ();
  logic valid;
  logic ready;
  logic switch_on;
  logic led_on;

  modport source (output valid, output switch_on, output led_on, input ready);
  modport sink   (input valid, input switch_on, input led_on, output ready);
endinterface

/* src/ptsc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style write/read access to the five timing and on-time registers.
// ----------------------------------------------------------------------------
module ptsc_cfg_regs import ptsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t           cfg_q;
  logic           wr_en;
  logic [RegIdxW-1:0] idx;

  // Word index; the two low address bits are ignored.
  assign idx    = paddr[PaddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= DebounceReset;
      cfg_q.double_press_ticks <= DoubleReset;
      cfg_q.blink_ticks        <= BlinkReset;
      cfg_q.ontime_gain        <= GainReset;
      cfg_q.ontime_base        <= BaseReset;
    end else if (wr_en) begin
      unique case (idx)
        RegDebounce: cfg_q.debounce_ticks     <= pwdata[DebW-1:0];
        RegDouble:   cfg_q.double_press_ticks <= pwdata[WinW-1:0];
        RegBlink:    cfg_q.blink_ticks        <= pwdata[BlinkW-1:0];
        RegGain:     cfg_q.ontime_gain        <= pwdata[GainW-1:0];
        RegBase:     cfg_q.ontime_base        <= pwdata[BaseW-1:0];
        default: ;
      endcase
    end
  end

  // Read multiplexer.
  always_comb begin
    prdata = '0;
    unique case (idx)
      RegDebounce: prdata = PdataW'(cfg_q.debounce_ticks);
      RegDouble:   prdata = PdataW'(cfg_q.double_press_ticks);
      RegBlink:    prdata = PdataW'(cfg_q.blink_ticks);
      RegGain:     prdata = PdataW'(cfg_q.ontime_gain);
      RegBase:     prdata = PdataW'(cfg_q.ontime_base);
      default:     prdata = '0;
    endcase
  end

endmodule

/* src/ptsc_core.sv */
// ----------------------------------------------------------------------------
// Controller core
// Lockout debouncer, three-mode state machine and blink timer; one tick per step.
// ----------------------------------------------------------------------------
module ptsc_core import ptsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               pedal_level_i,
  input  logic               pedal_absent_i,
  input  logic [SampleW-1:0] pot_sample_i,
  input  cfg_t               cfg_i,
  output result_t            res_o,
  output mode_e              mode_o
);

  mode_e              mode_q, mode_d;
  logic [DebW-1:0]    lock_q, lock_d;
  logic               last_q, last_d;
  logic [OntimeW-1:0] ontime_q, ontime_d;
  logic [WinW-1:0]    window_q, window_d;
  logic [BlinkW-1:0]  blink_q, blink_d;
  logic               phase_q, phase_d;
  logic               press;
  logic [ScaledW-1:0] scaled;
  logic [OntimeW-1:0] ontime_load;

  // On-time loaded at switch-on: base plus gain times the pot sample.
  assign scaled      = cfg_i.ontime_gain * pot_sample_i;
  assign ontime_load = OntimeW'(cfg_i.ontime_base) + OntimeW'(scaled);

  assign mode_o = mode_q;

  // Lockout debouncer: a level change is taken only once the lockout has expired.
  always_comb begin
    lock_d = lock_q;
    last_d = last_q;
    press  = 1'b0;
    if (lock_q == '0) begin
      if (pedal_level_i != last_q) begin
        lock_d = cfg_i.debounce_ticks;
        last_d = pedal_level_i;
        press  = pedal_level_i;
      end
    end else begin
      lock_d = lock_q - 1'b1;
    end
  end

  // Mode machine and output levels. A missing pedal freezes the machine.
  always_comb begin
    mode_d   = mode_q;
    ontime_d = ontime_q;
    window_d = window_q;
    blink_d  = blink_q;
    phase_d  = phase_q;
    res_o    = '0;
    if (pedal_absent_i) begin
      res_o.switch_on = 1'b1;
      res_o.led_on    = 1'b0;
    end else begin
      unique case (mode_q)
        ModeOff: begin
          if (press) begin
            mode_d   = ModeTimed;
            ontime_d = ontime_load;
            phase_d  = 1'b1;
            blink_d  = cfg_i.blink_ticks;
            window_d = cfg_i.double_press_ticks;
          end
        end
        ModeTimed: begin
          res_o.switch_on = 1'b1;
          res_o.led_on    = phase_q;
          if (blink_q == '0) begin
            blink_d = cfg_i.blink_ticks;
            phase_d = ~phase_q;
          end else begin
            blink_d = blink_q - 1'b1;
          end
          if (press) begin
            mode_d = (window_q == '0) ? ModeOff : ModeOn;
          end else if (ontime_q == '0) begin
            mode_d = ModeOff;
          end else begin
            ontime_d = ontime_q - 1'b1;
            if (window_q != '0) begin
              window_d = window_q - 1'b1;
            end
          end
        end
        ModeOn: begin
          res_o.switch_on = 1'b1;
          res_o.led_on    = 1'b1;
          if (press) begin
            mode_d = ModeOff;
          end
        end
        default: begin
          mode_d = ModeOff;
        end
      endcase
    end
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeOff;
      lock_q   <= '0;
      last_q   <= 1'b0;
      ontime_q <= '0;
      window_q <= '0;
      blink_q  <= '0;
      phase_q  <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      lock_q   <= lock_d;
      last_q   <= last_d;
      ontime_q <= ontime_d;
      window_q <= window_d;
      blink_q  <= blink_d;
      phase_q  <= phase_d;
    end
  end

endmodule

/* src/pedal_timed_switch_controller.sv */
// ----------------------------------------------------------------------------
// Pedal timed switch controller
// Debounced pedal press control of a load switch with timed and latched modes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Payload
//  in_i      in   valid / ready    pedal_level, pedal_absent, pot_sample
//  out_o     out  valid / ready    switch_on, led_on
//  apb       in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
//  Each tick passes through the input register, then the core logic and the
//  result register; one tick per cycle is sustained while results are taken.
//  The core holds a single 8x10 multiply feeding a 19-bit add in that stage.
//  A stalled result holds the result register; the input register still
//  fills behind it, and then ready drops until the result is taken.
//  Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pedal_timed_switch_controller import ptsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptsc_in_if.sink           in_i,
  ptsc_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cfg_t               cfg;
  result_t            res;
  mode_e              mode;
  logic               in_valid_q;
  logic               in_level_q;
  logic               in_absent_q;
  logic [SampleW-1:0] in_sample_q;
  logic               out_valid_q;
  result_t            out_q;
  logic               fire;

  // Configuration registers.
  ptsc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the core steps when a tick is held and the result slot is free.
  assign fire        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_level_q  <= in_i.pedal_level;
      in_absent_q <= in_i.pedal_absent;
      in_sample_q <= in_i.pot_sample;
    end
  end

  // Debouncer, mode machine and blink timer.
  ptsc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .pedal_level_i  (in_level_q),
    .pedal_absent_i (in_absent_q),
    .pot_sample_i   (in_sample_q),
    .cfg_i          (cfg),
    .res_o          (res),
    .mode_o         (mode)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.switch_on = out_q.switch_on;
  assign out_o.led_on    = out_q.led_on;

  // Checks on the pipeline control and result levels.
  `PTSC_ASSERT(a_absent_forces, fire && in_absent_q |=> out_q.switch_on && !out_q.led_on,
               "missing pedal did not force switch on, LED off")
  `PTSC_ASSERT(a_on_mode_lit,
               fire && !in_absent_q && mode == ModeOn |=> out_q.switch_on && out_q.led_on,
               "always-on mode did not drive switch and LED")
  `PTSC_ASSERT(a_led_needs_switch, out_valid_q && out_q.led_on |-> out_q.switch_on,
               "LED lit while switch off")
  `PTSC_ASSERT_ALWAYS(a_full_blocks, !(in_valid_q && out_valid_q && !out_o.ready && in_i.ready),
                      "input accepted while both stages are full and stalled")

endmodule
